>>> src/cist_pkg.sv
`timescale 1ns / 1ps
package cist_pkg;

  localparam int CARD_ID_W = 40;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;

  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FIRST   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LATER   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic                load;
    logic                advance;
    logic                write;
    logic                clear_all;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             first;
    logic             last;
    logic             hit;
    logic             free;
  } dp_stat_t;

endpackage

>>> src/cist_ctrl.sv
`timescale 1ns / 1ps
module cist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cist_pkg::dp_stat_t  dp_stat,
  output cist_pkg::dp_cmd_t   dp_cmd,
  output logic                busy
);

  cist_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cist_pkg::S_IDLE: begin
        if (start) begin
          state_next = cist_pkg::S_SCAN;
        end
      end
      cist_pkg::S_SCAN: begin
        if (dp_cmd.finish) begin
          state_next = cist_pkg::S_IDLE;
        end
      end
      default: state_next = cist_pkg::S_IDLE;
    endcase
  end

  // one slot examined per scan cycle
  always_comb begin
    dp_cmd = '0;
    unique case (state)
      cist_pkg::S_IDLE: begin
        dp_cmd.load = start;
      end
      cist_pkg::S_SCAN: begin
        unique case (dp_stat.command)
          cist_pkg::CMD_SEARCH: begin
            if (dp_stat.first && dp_stat.free) begin
              dp_cmd.finish = 1'b1;
              dp_cmd.status = cist_pkg::ST_EMPTY;
            end else if (dp_stat.hit) begin
              dp_cmd.finish = 1'b1;
              dp_cmd.status = dp_stat.first ? cist_pkg::ST_FIRST : cist_pkg::ST_LATER;
            end else if (dp_stat.last) begin
              dp_cmd.finish = 1'b1;
              dp_cmd.status = cist_pkg::ST_NONE;
            end else begin
              dp_cmd.advance = 1'b1;
            end
          end
          cist_pkg::CMD_STORE: begin
            if (dp_stat.free) begin
              dp_cmd.write  = 1'b1;
              dp_cmd.finish = 1'b1;
              dp_cmd.status = cist_pkg::ST_STORED;
            end else if (dp_stat.last) begin
              dp_cmd.finish = 1'b1;
              dp_cmd.status = cist_pkg::ST_FULL;
            end else begin
              dp_cmd.advance = 1'b1;
            end
          end
          cist_pkg::CMD_CLEAR: begin
            dp_cmd.clear_all = 1'b1;
            dp_cmd.finish    = 1'b1;
            dp_cmd.status    = cist_pkg::ST_CLEARED;
          end
          default: begin
            dp_cmd.finish = 1'b1;
            dp_cmd.status = cist_pkg::ST_NONE;
          end
        endcase
      end
      default: dp_cmd = '0;
    endcase
  end

  assign busy = (state != cist_pkg::S_IDLE);

endmodule

>>> src/cist_dp.sv
`timescale 1ns / 1ps
module cist_dp #(
  parameter int NUM_SLOTS = 32,
  parameter int ID_BYTES  = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cist_pkg::dp_cmd_t                   dp_cmd,
  input  logic [cist_pkg::CMD_W-1:0]          command,
  input  logic [cist_pkg::CARD_ID_W-1:0]      card_id,
  output cist_pkg::dp_stat_t                  dp_stat,
  output logic [cist_pkg::STATUS_W-1:0]       status,
  output logic                                done
);

  // stored id width is ID_BYTES bytes, capped at the port width; card_id bits above it are ignored
  localparam int ID_W  = (ID_BYTES * 8 < cist_pkg::CARD_ID_W) ? ID_BYTES * 8
                                                               : cist_pkg::CARD_ID_W;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [ID_W-1:0]            mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       valid;
  logic [IDX_W-1:0]           idx, idx_next;
  logic [ID_W-1:0]            id_reg;
  logic [cist_pkg::CMD_W-1:0] cmd_reg;
  logic [ID_W-1:0]            rd_data;
  logic                       rd_valid;
  logic [ID_W-1:0]            rd_word;

  always_comb begin
    if (dp_cmd.load || dp_cmd.finish) begin
      idx_next = '0;
    end else if (dp_cmd.advance) begin
      idx_next = idx + 1'b1;
    end else begin
      idx_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      idx  <= idx_next;
      done <= dp_cmd.finish;
      if (dp_cmd.clear_all) begin
        valid <= '0;
      end else if (dp_cmd.write) begin
        valid[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      id_reg  <= card_id[ID_W-1:0];
      cmd_reg <= command;
    end
    if (dp_cmd.finish) begin
      status <= dp_cmd.status;
    end
  end

  // slot memory, registered read of the slot the scan looks at next
  always_ff @(posedge clk) begin
    if (dp_cmd.write) begin
      mem[idx] <= id_reg;
    end
    rd_data  <= mem[idx_next];
    rd_valid <= valid[idx_next];
  end

  // a never-written slot reads as free
  assign rd_word = rd_valid ? rd_data : '0;

  assign dp_stat.command = cmd_reg;
  assign dp_stat.first   = (idx == '0);
  assign dp_stat.last    = (idx == LAST_IDX);
  assign dp_stat.hit     = (rd_word == id_reg);
  assign dp_stat.free    = (rd_word == '0);

endmodule

>>> src/card_id_slot_table_top.sv
`timescale 1ns / 1ps
// Walk: search and store examine slots from slot 0 and stop at the first slot that
//   decides the status, clear and the reserved command without a walk; the status strobe follows.
// Items: a new item is taken only while busy is low, after the one-slot-per-cycle
//   walk over the slot memory read port for the last item has ended.
// Reset (rst, synchronous, active high) frees every slot at once via the valid
//   bits; items are taken from the first cycle after reset. No receiver stall.
module card_id_slot_table_top #(
  parameter int NUM_SLOTS = 32,
  parameter int ID_BYTES  = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [cist_pkg::CMD_W-1:0]          command,
  input  logic [cist_pkg::CARD_ID_W-1:0]      card_id,
  output logic                                done,
  output logic [cist_pkg::STATUS_W-1:0]       status
);

  cist_pkg::dp_cmd_t  dp_cmd;
  cist_pkg::dp_stat_t dp_stat;

  // sequencer: walks the slots and decides the status
  cist_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd),
    .busy    (busy)
  );

  // slot memory, valid bits, scan index and result register
  cist_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_BYTES  (ID_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .dp_cmd  (dp_cmd),
    .command (command),
    .card_id (card_id),
    .dp_stat (dp_stat),
    .status  (status),
    .done    (done)
  );

endmodule

>>> src/cist_checker.sv
`timescale 1ns / 1ps
module cist_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [cist_pkg::STATUS_W-1:0] status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_end_strobe: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("item finished without result");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= cist_pkg::ST_CLEARED)
    else $error("undefined status code");

endmodule

bind card_id_slot_table_top cist_checker u_cist_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status)
);

>>> bench/card_id_slot_table_top_tb.sv
`timescale 1ns / 1ps
module card_id_slot_table_top_tb;

  localparam int CARD_ID_W   = cist_pkg::CARD_ID_W;
  localparam int CMD_W       = cist_pkg::CMD_W;
  localparam int STATUS_W    = cist_pkg::STATUS_W;

  localparam int NUM_SLOTS   = 32;
  localparam int ID_BYTES    = 5;
  localparam int ID_BITS     = ID_BYTES * 8;
  localparam int RANDOM_ITEMS = 1025;
  localparam int CYCLE_LIMIT = 500_000;

  // only the low ID_BYTES bytes of card_id take part in compares and writes
  localparam logic [CARD_ID_W-1:0] ID_MASK =
    (ID_BITS >= CARD_ID_W) ? '1 : ((CARD_ID_W'(1) << ID_BITS) - 1);

  // command 3 has no function: table untouched, answers "not found"
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     command = cist_pkg::CMD_SEARCH;
  logic [CARD_ID_W-1:0] card_id = '0;
  logic                 done;
  logic [STATUS_W-1:0]  status;

  card_id_slot_table_top #(
    .NUM_SLOTS(NUM_SLOTS),
    .ID_BYTES (ID_BYTES)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .command(command),
    .card_id(card_id),
    .done   (done),
    .status (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Slot table mirror: a copy of the slot contents, updated as each item is
  // taken, and the statuses still owed by the block, oldest first.
  // ---------------------------------------------------------------------------
  logic [CARD_ID_W-1:0] card_slots [NUM_SLOTS];
  logic [STATUS_W-1:0]  pending_status [$];

  int fail_count  = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int status_seen [8];

  // Applies one command to the mirror and returns the status it must give.
  function automatic logic [STATUS_W-1:0] apply_command(input logic [CMD_W-1:0] cmd,
                                                        input logic [CARD_ID_W-1:0] raw_id);
    logic [CARD_ID_W-1:0] id;
    id = raw_id & ID_MASK;
    case (cmd)
      cist_pkg::CMD_SEARCH: begin
        // a free first slot means an empty table, nothing else is looked at
        if (card_slots[0] == '0) return cist_pkg::ST_EMPTY;
        // free slots are compared too, so a zero id can hit a free later slot
        for (int k = 0; k < NUM_SLOTS; k++)
          if (card_slots[k] == id) return (k == 0) ? cist_pkg::ST_FIRST : cist_pkg::ST_LATER;
        return cist_pkg::ST_NONE;
      end
      cist_pkg::CMD_STORE: begin
        // no duplicate check; a zero id leaves the slot free but still "stored"
        for (int k = 0; k < NUM_SLOTS; k++)
          if (card_slots[k] == '0) begin
            card_slots[k] = id;
            return cist_pkg::ST_STORED;
          end
        return cist_pkg::ST_FULL;
      end
      cist_pkg::CMD_CLEAR: begin
        for (int k = 0; k < NUM_SLOTS; k++) card_slots[k] = '0;
        return cist_pkg::ST_CLEARED;
      end
      default: return cist_pkg::ST_NONE;
    endcase
  endfunction

  function automatic logic [CARD_ID_W-1:0] random_card_id();
    logic [CARD_ID_W-1:0] id;
    id = {8'($urandom), 32'($urandom)};
    return (id == '0) ? CARD_ID_W'(1) : id;
  endfunction

  function automatic int used_slots();
    int n;
    n = 0;
    for (int k = 0; k < NUM_SLOTS; k++) if (card_slots[k] != '0) n++;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Holds start until the item is taken (start high, busy low at the
  // edge). Items go out in bursts with start held high back to back; between
  // bursts start drops for a random gap, which lands on any phase of the walk.
  // ---------------------------------------------------------------------------
  task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [CARD_ID_W-1:0] id,
                            input bit typed, input logic [STATUS_W-1:0] typed_status);
    logic [STATUS_W-1:0] predicted;
    start   <= 1'b1;
    command <= cmd;
    card_id <= id;
    do @(posedge clk); while (busy);
    predicted = apply_command(cmd, id);
    pending_status.push_back(typed ? typed_status : predicted);
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // some bursts are long, giving stretches with no idle at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: one status per item, in order. done is a one-cycle strobe
  // and cannot be held off, so it is sampled at every edge.
  // ---------------------------------------------------------------------------
  logic [STATUS_W-1:0] oldest_status;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        $error("status: expected none outstanding, actual %0d", status);
        fail_count++;
      end else begin
        oldest_status = pending_status.pop_front();
        if (status !== oldest_status) begin
          $error("status: expected %0d, actual %0d", oldest_status, status);
          fail_count++;
        end
        status_seen[oldest_status]++;
      end
    end
  end

  // Watchdog: a stuck handshake or a lost strobe ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed items. Status typed in where it is obvious from the table
  // contents at that point; rows marked 0 in the typed column use the mirror.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [CARD_ID_W-1:0] id;
    logic                 typed;
    logic [STATUS_W-1:0]  st;
  } directed_row_t;

  localparam int NUM_DIRECTED = 24;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{cist_pkg::CMD_SEARCH, 40'h00_0000_0000, 1'b1, cist_pkg::ST_EMPTY},   // out of reset
    '{cist_pkg::CMD_SEARCH, 40'hFF_FFFF_FFFF, 1'b1, cist_pkg::ST_EMPTY},
    '{cist_pkg::CMD_STORE,  40'h00_0000_0000, 1'b1, cist_pkg::ST_STORED},  // slot stays free
    '{cist_pkg::CMD_SEARCH, 40'h00_0000_0000, 1'b1, cist_pkg::ST_EMPTY},
    '{CMD_RESERVED,         40'hFF_FFFF_FFFF, 1'b1, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_STORE,  40'hFF_FFFF_FFFF, 1'b1, cist_pkg::ST_STORED},  // slot 0
    '{cist_pkg::CMD_SEARCH, 40'hFF_FFFF_FFFF, 1'b1, cist_pkg::ST_FIRST},
    '{cist_pkg::CMD_SEARCH, 40'h00_0000_0000, 1'b1, cist_pkg::ST_LATER},   // free slot 1
    '{cist_pkg::CMD_SEARCH, 40'h00_0000_0001, 1'b0, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_STORE,  40'h80_0000_0000, 1'b1, cist_pkg::ST_STORED},  // slot 1
    '{cist_pkg::CMD_SEARCH, 40'h80_0000_0000, 1'b1, cist_pkg::ST_LATER},
    '{cist_pkg::CMD_STORE,  40'hFF_FFFF_FFFF, 1'b1, cist_pkg::ST_STORED},  // duplicate
    '{cist_pkg::CMD_SEARCH, 40'hFF_FFFF_FFFF, 1'b1, cist_pkg::ST_FIRST},   // first copy wins
    '{cist_pkg::CMD_STORE,  40'h00_0000_0000, 1'b1, cist_pkg::ST_STORED},
    '{cist_pkg::CMD_SEARCH, 40'h00_0000_0000, 1'b0, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_STORE,  40'h00_0000_0001, 1'b0, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_SEARCH, 40'h00_0000_0001, 1'b0, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_SEARCH, 40'h7F_FFFF_FFFF, 1'b0, cist_pkg::ST_NONE},
    '{CMD_RESERVED,         40'h00_0000_0000, 1'b1, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_CLEAR,  40'h12_3456_789A, 1'b1, cist_pkg::ST_CLEARED},
    '{cist_pkg::CMD_SEARCH, 40'h80_0000_0000, 1'b1, cist_pkg::ST_EMPTY},
    '{cist_pkg::CMD_STORE,  40'hA5_A5A5_A5A5, 1'b1, cist_pkg::ST_STORED},
    '{cist_pkg::CMD_SEARCH, 40'h5A_5A5A_5A5A, 1'b1, cist_pkg::ST_NONE},
    '{cist_pkg::CMD_CLEAR,  40'h00_0000_0000, 1'b1, cist_pkg::ST_CLEARED}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int store_pct;
    int run_len;
    int pick;
    int random_sent;
    int drain_wait;

    for (int k = 0; k < NUM_SLOTS; k++) card_slots[k] = '0;
    for (int k = 0; k < 8; k++) status_seen[k] = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++)
      issue_item(directed_rows[r].cmd, directed_rows[r].id, directed_rows[r].typed,
                 directed_rows[r].st);

    // Random part in runs: each run starts from a cleared table and has its
    // own store rate, so some runs stay sparse and others fill the table and
    // keep hitting it while full. Searches mostly look for ids in the table.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      issue_item(cist_pkg::CMD_CLEAR, random_card_id(), 1'b0, cist_pkg::ST_NONE);
      random_sent++;
      case ($urandom_range(0, 2))
        0:       store_pct = 15;
        1:       store_pct = 45;
        default: store_pct = 85;
      endcase
      run_len = (store_pct == 85) ? $urandom_range(40, 90) : $urandom_range(8, 60);
      for (int i = 0; i < run_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < store_pct) begin
          pick = $urandom_range(0, 99);
          if (pick < 6)
            issue_item(cist_pkg::CMD_STORE, '0, 1'b0, cist_pkg::ST_NONE);
          else if (pick < 14)
            issue_item(cist_pkg::CMD_STORE, card_slots[$urandom_range(0, NUM_SLOTS - 1)],
                       1'b0, cist_pkg::ST_NONE);
          else
            issue_item(cist_pkg::CMD_STORE, random_card_id(), 1'b0, cist_pkg::ST_NONE);
        end else begin
          pick = $urandom_range(0, 99);
          // table full: the zero id search has nowhere free to land
          if (used_slots() == NUM_SLOTS && pick < 25)
            issue_item(cist_pkg::CMD_SEARCH, '0, 1'b0, cist_pkg::ST_NONE);
          else if (pick < 55)
            issue_item(cist_pkg::CMD_SEARCH, card_slots[$urandom_range(0, NUM_SLOTS - 1)],
                       1'b0, cist_pkg::ST_NONE);
          else if (pick < 75)
            issue_item(cist_pkg::CMD_SEARCH, random_card_id(), 1'b0, cist_pkg::ST_NONE);
          else if (pick < 85)
            issue_item(cist_pkg::CMD_SEARCH, '0, 1'b0, cist_pkg::ST_NONE);
          else if (pick < 93)
            issue_item(CMD_RESERVED, random_card_id(), 1'b0, cist_pkg::ST_NONE);
          else
            issue_item(cist_pkg::CMD_CLEAR, random_card_id(), 1'b0, cist_pkg::ST_NONE);
        end
        random_sent++;
      end
    end

    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    // catch a stray strobe after the last one
    drain_wait = NUM_SLOTS + 8;
    repeat (drain_wait) @(posedge clk);

    $display("Ran %0d items over random fill/search/clear runs with bursty start.",
             items_sent);
    $display("Statuses: empty %0d first %0d later %0d none %0d stored %0d full %0d clr %0d",
             status_seen[cist_pkg::ST_EMPTY], status_seen[cist_pkg::ST_FIRST],
             status_seen[cist_pkg::ST_LATER], status_seen[cist_pkg::ST_NONE],
             status_seen[cist_pkg::ST_STORED], status_seen[cist_pkg::ST_FULL],
             status_seen[cist_pkg::ST_CLEARED]);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/cist_pkg.sv
src/cist_ctrl.sv
src/cist_dp.sv
src/card_id_slot_table_top.sv
src/cist_checker.sv
bench/card_id_slot_table_top_tb.sv
